// ----- hw/rtl/dtta_pkg.sv -----
// ----------------------------------------------------------------------------
// Dual timer TOD adapter package
// Shared payload types, command codes, register addresses and helper functions.
// ----------------------------------------------------------------------------
package dtta_pkg;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_CNT   = 2'd3
   } cmd_type;

   localparam logic [3:0] REG_PRA  = 4'h0;
   localparam logic [3:0] REG_PRB  = 4'h1;
   localparam logic [3:0] REG_DDRA = 4'h2;
   localparam logic [3:0] REG_DDRB = 4'h3;
   localparam logic [3:0] REG_TALO = 4'h4;
   localparam logic [3:0] REG_TAHI = 4'h5;
   localparam logic [3:0] REG_TBLO = 4'h6;
   localparam logic [3:0] REG_TBHI = 4'h7;
   localparam logic [3:0] REG_TOD0 = 4'h8;
   localparam logic [3:0] REG_TOD1 = 4'h9;
   localparam logic [3:0] REG_TOD2 = 4'hA;
   localparam logic [3:0] REG_TOD3 = 4'hB;
   localparam logic [3:0] REG_SDR  = 4'hC;
   localparam logic [3:0] REG_ICR  = 4'hD;
   localparam logic [3:0] REG_CRA  = 4'hE;
   localparam logic [3:0] REG_CRB  = 4'hF;

   localparam logic [19:0] CYCLES_RESET = 20'd98525;

   typedef struct packed {
      cmd_type    cmd;
      logic [3:0] reg_addr;
      logic [7:0] write_data;
      logic       cnt_pin;
      logic [7:0] pulldown_a;
      logic [7:0] pulldown_b;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq;
      logic [7:0] port_a_pins;
      logic [7:0] port_b_pins;
   } rsp_type;

   typedef struct packed {
      logic [15:0] count;
      logic [7:0]  ctrl;
      logic        under;
   } tmr_type;

   function automatic tmr_type count_timer(input logic [15:0] cnt,
                                           input logic [15:0] latch,
                                           input logic [7:0] ctrl);
      tmr_type r;
      logic [15:0] dec;
      dec = cnt - 16'd1;
      r.count = cnt;
      r.ctrl = ctrl;
      r.under = 1'b0;
      if (cnt == 16'd0) begin
         r.count = latch;
      end else if (dec != 16'd0) begin
         r.count = dec;
      end else begin
         r.count = latch;
         r.under = 1'b1;
         if (ctrl[3]) begin
            r.ctrl[0] = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic logic [8:0] digit_inc(input logic [3:0] d, input logic [3:0] max);
      logic [4:0] n;
      n = {1'b0, d} + 5'd1;
      if (n > {1'b0, max}) begin
         return {1'b1, 8'd0};
      end
      return {1'b0, 4'd0, n[3:0]};
   endfunction

   function automatic logic [31:0] tod_advance(input logic [31:0] t);
      logic [31:0] r;
      logic [8:0]  d;
      logic        c;
      logic        pm;
      logic [4:0]  hr;
      r = t;
      d = digit_inc(t[3:0], 4'd9);
      r[3:0] = d[3:0];
      c = d[8];
      if (c) begin
         d = digit_inc(t[11:8], 4'd9); r[11:8] = d[3:0]; c = d[8];
         if (c) begin
            d = digit_inc(t[15:12], 4'd5); r[15:12] = d[3:0]; c = d[8];
         end
      end
      if (c) begin
         d = digit_inc(t[19:16], 4'd9); r[19:16] = d[3:0]; c = d[8];
         if (c) begin
            d = digit_inc(t[23:20], 4'd5); r[23:20] = d[3:0]; c = d[8];
         end
      end
      if (c) begin
         pm = t[31];
         hr = (t[28] ? 5'd10 : 5'd0) + {1'b0, t[27:24]} + 5'd1;
         if (hr > 5'd12) begin
            hr = 5'd1;
            pm = ~pm;
         end
         if (hr >= 5'd10) begin
            r[31:24] = {pm, 3'b001, 4'(hr - 5'd10)};
         end else begin
            r[31:24] = {pm, 3'b000, hr[3:0]};
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] pins(input logic [7:0] o, input logic [7:0] dir,
                                       input logic [7:0] pull);
      return ((o & dir) | ~dir) & ~pull;
   endfunction

endpackage

// ----- hw/rtl/dual_timer_tod_interface_adapter_core.sv -----
// ----------------------------------------------------------------------------
// Dual timer TOD interface adapter core
// Two ports, two 16-bit timers, BCD time-of-day clock with alarm.
// ----------------------------------------------------------------------------
// Usage: each transfer on the req_ channel carries one command: a register
// read, a register write, one bus clock tick or a new CNT pin level. Every
// command yields exactly one transfer on the rsp_ channel with the read data,
// the interrupt line and the effective port pin levels after the command.
// The whole command is applied in the cycle it is accepted and its response
// is held in an output register, so the response is valid in the cycle after
// acceptance; one command can be accepted every cycle while the receiver does
// not stall. Timer, TOD and interrupt registers all update in the accepting cycle.
// When the receiver stalls, the response register holds its transfer and
// req_stall rises only while a waiting response would be overwritten; a new
// command is taken in the same cycle the waiting response leaves.
// The csr_ port writes the TOD tenth-second period in clock ticks; zero stops
// the TOD clock.
// A synchronous reset clears the response valid and restores every register but
// the response data to its reset value, with the tenth-second period at 98525.
// ----------------------------------------------------------------------------
module dual_timer_tod_interface_adapter_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dtta_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dtta_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [19:0]      csr_data
);

   logic [19:0] period_ff;
   logic [7:0]  pa_out_ff, pb_out_ff, dir_a_ff, dir_b_ff;
   logic [15:0] ta_latch_ff, tb_latch_ff, ta_cnt_ff, tb_cnt_ff;
   logic [7:0]  cra_ff, crb_ff;
   logic [31:0] tod_ff, alarm_ff, snap_ff;
   logic        held_ff, tod_en_ff, cnt_ff;
   logic [19:0] accum_ff;
   logic [7:0]  sdr_ff;
   logic [4:0]  flags_ff, mask_ff;
   logic        rsp_valid_ff;
   dtta_pkg::rsp_type rsp_ff;

   logic [7:0]  pa_out_in, pb_out_in, dir_a_in, dir_b_in;
   logic [15:0] ta_latch_in, tb_latch_in, ta_cnt_in, tb_cnt_in;
   logic [7:0]  cra_in, crb_in;
   logic [31:0] tod_in, alarm_in, snap_in;
   logic        held_in, tod_en_in, cnt_in;
   logic [19:0] accum_in;
   logic [7:0]  sdr_in;
   logic [4:0]  flags_in, mask_in;
   dtta_pkg::rsp_type rsp_in;

   logic accept;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      dtta_pkg::tmr_type ta, tb;
      logic a_ev, b_ev, a_under, rise, alm;
      logic [7:0] rd, wd;
      logic [31:0] nt;
      pa_out_in = pa_out_ff; pb_out_in = pb_out_ff;
      dir_a_in = dir_a_ff; dir_b_in = dir_b_ff;
      ta_latch_in = ta_latch_ff; tb_latch_in = tb_latch_ff;
      ta_cnt_in = ta_cnt_ff; tb_cnt_in = tb_cnt_ff;
      cra_in = cra_ff; crb_in = crb_ff;
      tod_in = tod_ff; alarm_in = alarm_ff; snap_in = snap_ff;
      held_in = held_ff; tod_en_in = tod_en_ff; cnt_in = cnt_ff;
      accum_in = accum_ff; sdr_in = sdr_ff;
      flags_in = flags_ff; mask_in = mask_ff;
      rd = 8'd0;
      wd = req_data.write_data;
      alm = crb_ff[7];
      a_ev = 1'b0;
      b_ev = 1'b0;
      a_under = 1'b0;
      rise = 1'b0;
      nt = 32'd0;
      ta = dtta_pkg::count_timer(ta_cnt_ff, ta_latch_ff, cra_ff);
      case (req_data.cmd)
         dtta_pkg::CMD_READ: begin
            unique case (req_data.reg_addr)
               dtta_pkg::REG_PRA:
                  rd = dtta_pkg::pins(pa_out_ff, dir_a_ff, req_data.pulldown_a);
               dtta_pkg::REG_PRB:
                  rd = dtta_pkg::pins(pb_out_ff, dir_b_ff, req_data.pulldown_b);
               dtta_pkg::REG_DDRA: rd = dir_a_ff;
               dtta_pkg::REG_DDRB: rd = dir_b_ff;
               dtta_pkg::REG_TALO: rd = ta_cnt_ff[7:0];
               dtta_pkg::REG_TAHI: rd = ta_cnt_ff[15:8];
               dtta_pkg::REG_TBLO: rd = tb_cnt_ff[7:0];
               dtta_pkg::REG_TBHI: rd = tb_cnt_ff[15:8];
               dtta_pkg::REG_TOD0: begin
                  rd = held_ff ? snap_ff[7:0] : tod_ff[7:0];
                  held_in = 1'b0;
               end
               dtta_pkg::REG_TOD1: rd = held_ff ? snap_ff[15:8] : tod_ff[15:8];
               dtta_pkg::REG_TOD2: rd = held_ff ? snap_ff[23:16] : tod_ff[23:16];
               dtta_pkg::REG_TOD3: begin
                  if (!held_ff) begin
                     snap_in = tod_ff;
                     held_in = 1'b1;
                     rd = tod_ff[31:24];
                  end else begin
                     rd = snap_ff[31:24];
                  end
               end
               dtta_pkg::REG_SDR: rd = sdr_ff;
               dtta_pkg::REG_ICR: begin
                  rd = {|(flags_ff & mask_ff), 2'b00, flags_ff};
                  flags_in = 5'd0;
               end
               dtta_pkg::REG_CRA: rd = cra_ff;
               default: rd = crb_ff;
            endcase
         end
         dtta_pkg::CMD_WRITE: begin
            unique case (req_data.reg_addr)
               dtta_pkg::REG_PRA: pa_out_in = wd;
               dtta_pkg::REG_PRB: pb_out_in = wd;
               dtta_pkg::REG_DDRA: dir_a_in = wd;
               dtta_pkg::REG_DDRB: dir_b_in = wd;
               dtta_pkg::REG_TALO: ta_latch_in = {ta_latch_ff[15:8], wd};
               dtta_pkg::REG_TAHI: begin
                  ta_latch_in = {wd, ta_latch_ff[7:0]};
                  if (!cra_ff[0]) ta_cnt_in = {wd, ta_latch_ff[7:0]};
               end
               dtta_pkg::REG_TBLO: tb_latch_in = {tb_latch_ff[15:8], wd};
               dtta_pkg::REG_TBHI: begin
                  tb_latch_in = {wd, tb_latch_ff[7:0]};
                  if (!crb_ff[0]) tb_cnt_in = {wd, tb_latch_ff[7:0]};
               end
               dtta_pkg::REG_TOD0: begin
                  if (alm) begin
                     alarm_in[7:0] = {4'd0, wd[3:0]};
                  end else begin
                     tod_in[7:0] = {4'd0, wd[3:0]};
                     tod_en_in = 1'b1;
                  end
               end
               dtta_pkg::REG_TOD1: begin
                  if (alm) alarm_in[15:8] = wd;
                  else tod_in[15:8] = wd;
               end
               dtta_pkg::REG_TOD2: begin
                  if (alm) alarm_in[23:16] = wd;
                  else tod_in[23:16] = wd;
               end
               dtta_pkg::REG_TOD3: begin
                  if (alm) begin
                     alarm_in[31:24] = wd;
                  end else begin
                     tod_in[31:24] = wd;
                     tod_en_in = 1'b0;
                  end
               end
               dtta_pkg::REG_SDR: sdr_in = wd;
               dtta_pkg::REG_ICR: begin
                  if (wd[7]) mask_in = mask_ff | wd[4:0];
                  else mask_in = mask_ff & ~wd[4:0];
               end
               dtta_pkg::REG_CRA: begin
                  cra_in = wd & 8'hEF;
                  if (wd[4]) ta_cnt_in = ta_latch_ff;
               end
               default: begin
                  crb_in = wd & 8'hEF;
                  if (wd[4]) tb_cnt_in = tb_latch_ff;
               end
            endcase
         end
         dtta_pkg::CMD_TICK: begin
            a_ev = cra_ff[0] & ~cra_ff[5];
            a_under = a_ev & ta.under;
            b_ev = crb_ff[0] & ((crb_ff[6:5] == 2'd0) |
                   (a_under & ((crb_ff[6:5] == 2'd2) | ((crb_ff[6:5] == 2'd3) & cnt_ff))));
            if (tod_en_ff && period_ff != 20'd0) begin
               if ({1'b0, accum_ff} + 21'd1 >= {1'b0, period_ff}) begin
                  accum_in = 20'd0;
                  nt = dtta_pkg::tod_advance(tod_ff);
                  tod_in = nt;
                  if (nt == alarm_ff) flags_in[2] = 1'b1;
               end else begin
                  accum_in = accum_ff + 20'd1;
               end
            end
         end
         default: begin
            rise = req_data.cnt_pin & ~cnt_ff;
            cnt_in = req_data.cnt_pin;
            a_ev = rise & cra_ff[0] & cra_ff[5];
            a_under = a_ev & ta.under;
            b_ev = rise & crb_ff[0] & ((crb_ff[6:5] == 2'd1) |
                   (a_under & ((crb_ff[6:5] == 2'd2) | ((crb_ff[6:5] == 2'd3) & cnt_in))));
         end
      endcase
      tb = dtta_pkg::count_timer(tb_cnt_ff, tb_latch_ff, crb_ff);
      if (a_ev) begin
         ta_cnt_in = ta.count;
         cra_in = ta.ctrl;
         if (ta.under) flags_in[0] = 1'b1;
      end
      if (b_ev) begin
         tb_cnt_in = tb.count;
         crb_in = tb.ctrl;
         if (tb.under) flags_in[1] = 1'b1;
      end
      rsp_in.read_data = rd;
      rsp_in.irq = |(flags_in & mask_in);
      rsp_in.port_a_pins = dtta_pkg::pins(pa_out_in, dir_a_in, req_data.pulldown_a);
      rsp_in.port_b_pins = dtta_pkg::pins(pb_out_in, dir_b_in, req_data.pulldown_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= dtta_pkg::CYCLES_RESET;
      end else if (csr_write) begin
         period_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pa_out_ff <= 8'd0; pb_out_ff <= 8'd0; dir_a_ff <= 8'd0; dir_b_ff <= 8'd0;
         ta_latch_ff <= 16'hFFFF; tb_latch_ff <= 16'hFFFF;
         ta_cnt_ff <= 16'd0; tb_cnt_ff <= 16'd0;
         cra_ff <= 8'd0; crb_ff <= 8'd0;
         tod_ff <= 32'd0; alarm_ff <= 32'd0; snap_ff <= 32'd0;
         held_ff <= 1'b0; tod_en_ff <= 1'b1; cnt_ff <= 1'b0;
         accum_ff <= 20'd0; sdr_ff <= 8'd0;
         flags_ff <= 5'd0; mask_ff <= 5'd0;
      end else begin
         if (accept) begin
            rsp_valid_ff <= 1'b1;
            pa_out_ff <= pa_out_in; pb_out_ff <= pb_out_in;
            dir_a_ff <= dir_a_in; dir_b_ff <= dir_b_in;
            ta_latch_ff <= ta_latch_in; tb_latch_ff <= tb_latch_in;
            ta_cnt_ff <= ta_cnt_in; tb_cnt_ff <= tb_cnt_in;
            cra_ff <= cra_in; crb_ff <= crb_in;
            tod_ff <= tod_in; alarm_ff <= alarm_in; snap_ff <= snap_in;
            held_ff <= held_in; tod_en_ff <= tod_en_in; cnt_ff <= cnt_in;
            accum_ff <= accum_in; sdr_ff <= sdr_in;
            flags_ff <= flags_in; mask_ff <= mask_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
